// File: rtl/core/bpq_pkg.sv
package bpq_pkg;

  localparam int unsigned NUM_BUCKETS  = 256;
  localparam int unsigned BUCKET_DEPTH = 16;
  localparam int unsigned VALUE_WIDTH  = 32;

  localparam int unsigned BKT_W    = $clog2(NUM_BUCKETS);
  localparam int unsigned FILL_W   = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned ENTRIES  = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int unsigned ENTRY_AW = $clog2(ENTRIES);
  localparam int unsigned TOTAL_W  = $clog2(ENTRIES + 1);

  localparam int unsigned KEY_W        = 16;
  localparam int unsigned VALUE_PORT_W = 32;
  localparam int unsigned POP_KEY_W    = 8;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OCC_W        = 13;

  typedef enum logic [STATUS_W-1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusEmpty = 2'd2,
    StatusFull  = 2'd3
  } status_e;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } command_e;

  typedef struct packed {
    logic             found;
    logic [BKT_W-1:0] idx;
  } lowest_t;

endpackage

// File: rtl/core/bpq_ram.sv
module bpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bpq_lowest.sv
module bpq_lowest (
  input  logic [bpq_pkg::NUM_BUCKETS-1:0] nonempty_i,
  output bpq_pkg::lowest_t                lowest_o
);

  logic [bpq_pkg::NUM_BUCKETS-1:0] first_bit;
  logic [bpq_pkg::BKT_W-1:0]       idx;

  // isolate the lowest set bit, then encode the one-hot word
  assign first_bit = nonempty_i & (~nonempty_i + 1'b1);

  always_comb begin
    idx = '0;
    for (int j = 0; j < int'(bpq_pkg::BKT_W); j++) begin
      for (int i = 0; i < int'(bpq_pkg::NUM_BUCKETS); i++) begin
        if (((i >> j) & 1) != 0) begin
          idx[j] = idx[j] | first_bit[i];
        end
      end
    end
  end

  assign lowest_o.found = |nonempty_i;
  assign lowest_o.idx   = idx;

endmodule

// File: rtl/core/bucket_priority_queue.sv
// Bucket priority queue with a fixed number of LIFO buckets.
// Command channel: a command (push key/value or pop) is taken at a rising edge
// with start high and busy low. busy stays high while the command works.
// Result channel: result_valid_o is high for exactly one cycle with pop_value_o,
// pop_key_o, status_o and occupancy_o; the receiver must take it then.
// Steps from the accepting edge to the result cycle:
//   push, key in range       : fill read, then fill and entry write
//   pop, queue not empty     : fill read, entry read, result
//   push out of range, empty : result registered at the accepting edge
// The next command may be accepted in the result cycle; until then busy holds
// off new commands, so one command is worked at a time on the single-port fill
// and entry memories. The lowest non-empty bucket comes from a priority encoder
// over one occupancy bit per bucket, which also masks stale fill counts.
// Reset clears the occupancy bits and the item count; no clearing pass is
// needed, so a command may be accepted in the first cycle after reset.
// A push into a full bucket is dropped with status 3, a key beyond the bucket
// range gives status 1, a pop from an empty queue gives status 2.
module bucket_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [15:0] key_i,
  input  logic [31:0] value_i,
  output logic        result_valid_o,
  output logic [31:0] pop_value_o,
  output logic [7:0]  pop_key_o,
  output logic [1:0]  status_o,
  output logic [12:0] occupancy_o
);

  typedef enum logic [1:0] {
    StIdle,
    StFillRd,
    StEntryRd
  } state_e;

  state_e                                state_q, state_d;
  logic [bpq_pkg::BKT_W-1:0]             bucket_q, bucket_d;
  bpq_pkg::command_e                     cmd_q, cmd_d;
  logic [bpq_pkg::VALUE_WIDTH-1:0]       value_q, value_d;
  logic [bpq_pkg::TOTAL_W-1:0]           total_q, total_d;
  logic [bpq_pkg::NUM_BUCKETS-1:0]       nonempty_q, nonempty_d;
  logic                                  valid_q, valid_d;
  logic [bpq_pkg::VALUE_PORT_W-1:0]      pop_value_q, pop_value_d;
  logic [bpq_pkg::POP_KEY_W-1:0]         pop_key_q, pop_key_d;
  bpq_pkg::status_e                      status_q, status_d;

  logic                                  accept;
  logic                                  key_in_range;
  bpq_pkg::lowest_t                      lowest;
  logic [bpq_pkg::BKT_W-1:0]             fill_addr;
  logic                                  fill_we;
  logic [bpq_pkg::FILL_W-1:0]            fill_wdata;
  logic [bpq_pkg::FILL_W-1:0]            fill_rdata;
  logic [bpq_pkg::FILL_W-1:0]            fill_cur;
  logic [bpq_pkg::FILL_W-1:0]            slot;
  logic [bpq_pkg::ENTRY_AW-1:0]          entry_addr;
  logic                                  entry_we;
  logic [bpq_pkg::VALUE_WIDTH-1:0]       entry_rdata;

  assign accept       = start && !busy;
  assign key_in_range = 32'(key_i) < 32'(bpq_pkg::NUM_BUCKETS);
  assign fill_cur     = nonempty_q[bucket_q] ? fill_rdata : '0;
  assign slot         = (cmd_q == bpq_pkg::CmdPush) ? fill_cur : fill_cur - 1'b1;
  assign entry_addr   = bpq_pkg::ENTRY_AW'(bpq_pkg::ENTRY_AW'(bucket_q)
                        * bpq_pkg::ENTRY_AW'(bpq_pkg::BUCKET_DEPTH))
                        + bpq_pkg::ENTRY_AW'(slot);

  bpq_lowest u_lowest (
    .nonempty_i (nonempty_q),
    .lowest_o   (lowest)
  );

  bpq_ram #(
    .Width (bpq_pkg::FILL_W),
    .Depth (bpq_pkg::NUM_BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .addr_i  (fill_addr),
    .wdata_i (fill_wdata),
    .rdata_o (fill_rdata)
  );

  bpq_ram #(
    .Width (bpq_pkg::VALUE_WIDTH),
    .Depth (bpq_pkg::ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (entry_we),
    .addr_i  (entry_addr),
    .wdata_i (value_q),
    .rdata_o (entry_rdata)
  );

  always_comb begin
    state_d     = state_q;
    bucket_d    = bucket_q;
    cmd_d       = cmd_q;
    value_d     = value_q;
    total_d     = total_q;
    nonempty_d  = nonempty_q;
    valid_d     = 1'b0;
    pop_value_d = pop_value_q;
    pop_key_d   = pop_key_q;
    status_d    = status_q;
    fill_addr   = bucket_q;
    fill_we     = 1'b0;
    fill_wdata  = fill_cur + 1'b1;
    entry_we    = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_d   = bpq_pkg::command_e'(command_i);
          value_d = bpq_pkg::VALUE_WIDTH'(value_i);
          if (command_i == bpq_pkg::CmdPush) begin
            if (key_in_range) begin
              bucket_d  = key_i[bpq_pkg::BKT_W-1:0];
              fill_addr = key_i[bpq_pkg::BKT_W-1:0];
              state_d   = StFillRd;
            end else begin
              valid_d     = 1'b1;
              pop_value_d = '0;
              pop_key_d   = '0;
              status_d    = bpq_pkg::StatusRange;
            end
          end else begin
            if (total_q == '0 || !lowest.found) begin
              valid_d     = 1'b1;
              pop_value_d = '0;
              pop_key_d   = '0;
              status_d    = bpq_pkg::StatusEmpty;
            end else begin
              bucket_d  = lowest.idx;
              fill_addr = lowest.idx;
              state_d   = StFillRd;
            end
          end
        end
      end
      StFillRd: begin
        if (cmd_q == bpq_pkg::CmdPush) begin
          valid_d     = 1'b1;
          pop_value_d = '0;
          pop_key_d   = '0;
          state_d     = StIdle;
          if (fill_cur == bpq_pkg::FILL_W'(bpq_pkg::BUCKET_DEPTH)) begin
            status_d = bpq_pkg::StatusFull;
          end else begin
            status_d             = bpq_pkg::StatusOk;
            fill_we              = 1'b1;
            fill_wdata           = fill_cur + 1'b1;
            entry_we             = 1'b1;
            nonempty_d[bucket_q] = 1'b1;
            total_d              = total_q + 1'b1;
          end
        end else begin
          fill_we    = 1'b1;
          fill_wdata = fill_cur - 1'b1;
          total_d    = total_q - 1'b1;
          if (fill_cur == bpq_pkg::FILL_W'(1)) begin
            nonempty_d[bucket_q] = 1'b0;
          end
          state_d = StEntryRd;
        end
      end
      StEntryRd: begin
        valid_d     = 1'b1;
        pop_value_d = bpq_pkg::VALUE_PORT_W'(entry_rdata);
        pop_key_d   = bpq_pkg::POP_KEY_W'(bucket_q);
        status_d    = bpq_pkg::StatusOk;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bucket_q    <= '0;
      cmd_q       <= bpq_pkg::CmdPush;
      value_q     <= '0;
      total_q     <= '0;
      nonempty_q  <= '0;
      valid_q     <= 1'b0;
      pop_value_q <= '0;
      pop_key_q   <= '0;
      status_q    <= bpq_pkg::StatusOk;
    end else begin
      state_q     <= state_d;
      bucket_q    <= bucket_d;
      cmd_q       <= cmd_d;
      value_q     <= value_d;
      total_q     <= total_d;
      nonempty_q  <= nonempty_d;
      valid_q     <= valid_d;
      pop_value_q <= pop_value_d;
      pop_key_q   <= pop_key_d;
      status_q    <= status_d;
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;
  assign pop_value_o    = pop_value_q;
  assign pop_key_o      = pop_key_q;
  assign status_o       = status_q;
  assign occupancy_o    = bpq_pkg::OCC_W'(total_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_q == '0) == (total_q == '0))
    else $error("occupancy bits disagree with item count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q == bpq_pkg::StatusEmpty |-> total_q == '0)
    else $error("empty status while items are stored");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == bpq_pkg::CmdPush && !key_in_range
    |=> valid_q && status_q == bpq_pkg::StatusRange && state_q == StIdle)
    else $error("out-of-range push not reported in next cycle");

endmodule

// File: tb/tb_bucket_priority_queue.sv
`timescale 1ns / 1ps

module tb_bucket_priority_queue;
  import bpq_pkg::*;

  localparam logic [VALUE_PORT_W-1:0] VAL_MASK =
    (VALUE_WIDTH >= VALUE_PORT_W) ? '1 : VALUE_PORT_W'((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef struct {
    command_e                op;
    logic [KEY_W-1:0]        key;
    logic [VALUE_PORT_W-1:0] value;
    int unsigned             gap_pct;
    bit                      drain_first;
  } queue_cmd_t;

  typedef struct {
    logic [VALUE_PORT_W-1:0] value;
    logic [POP_KEY_W-1:0]    key;
    status_e                 status;
    logic [OCC_W-1:0]        occ;
  } reply_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    command_i = 1'b0;
  logic [KEY_W-1:0]        key_i = '0;
  logic [VALUE_PORT_W-1:0] value_i = '0;
  logic                    result_valid_o;
  logic [VALUE_PORT_W-1:0] pop_value_o;
  logic [POP_KEY_W-1:0]    pop_key_o;
  logic [STATUS_W-1:0]     status_o;
  logic [OCC_W-1:0]        occupancy_o;

  queue_cmd_t cmd_q[$];
  reply_t     reply_q[$];

  int unsigned             fill_cnt[NUM_BUCKETS];
  logic [VALUE_PORT_W-1:0] slot_val[NUM_BUCKETS][BUCKET_DEPTH];
  int unsigned             low_bkt = NUM_BUCKETS;
  int unsigned             item_cnt = 0;

  int          n_issued = 0;
  int          n_returned = 0;
  int          n_bad = 0;
  int unsigned cur_gap = 0;
  bit          pause_next = 1'b0;

  bucket_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .pop_value_o    (pop_value_o),
    .pop_key_o      (pop_key_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void add_cmd(command_e op, int unsigned key, logic [31:0] value);
    queue_cmd_t c;
    c.op          = op;
    c.key         = KEY_W'(key);
    c.value       = value;
    c.gap_pct     = cur_gap;
    c.drain_first = pause_next;
    pause_next    = 1'b0;
    cmd_q.push_back(c);
  endfunction

  function automatic void apply_command(queue_cmd_t c);
    reply_t      r;
    int unsigned k;
    int unsigned b;
    r.value  = '0;
    r.key    = '0;
    r.status = StatusOk;
    k = c.key;
    b = low_bkt;
    if (c.op == CmdPush) begin
      if (k >= NUM_BUCKETS) begin
        r.status = StatusRange;
      end else if (fill_cnt[k] >= BUCKET_DEPTH) begin
        r.status = StatusFull;
      end else begin
        slot_val[k][fill_cnt[k]] = c.value & VAL_MASK;
        fill_cnt[k]++;
        item_cnt++;
        if (k < low_bkt) low_bkt = k;
      end
    end else if (item_cnt == 0) begin
      r.status = StatusEmpty;
    end else begin
      while (b < NUM_BUCKETS && fill_cnt[b] == 0) b++;
      if (b >= NUM_BUCKETS) begin
        r.status = StatusEmpty;
      end else begin
        low_bkt = b;
        fill_cnt[b]--;
        r.value = slot_val[b][fill_cnt[b]];
        r.key   = POP_KEY_W'(b);
        item_cnt--;
      end
    end
    r.occ = OCC_W'(item_cnt);
    reply_q.push_back(r);
  endfunction

  function automatic void build_phase(int unsigned n_items, int unsigned gap);
    int unsigned n;
    int unsigned seg_len;
    int unsigned span;
    int unsigned base;
    int unsigned push_pct;
    int unsigned roll;
    n = 0;
    cur_gap = gap;
    pause_next = 1'b1;
    while (n < n_items) begin
      seg_len = $urandom_range(60, 10);
      case ($urandom_range(3))
        0: span = 1;
        1: span = 8;
        2: span = NUM_BUCKETS;
        default: span = $urandom_range(64, 2);
      endcase
      base = $urandom_range(NUM_BUCKETS - span);
      push_pct = $urandom_range(85, 15);
      for (int i = 0; i < seg_len && n < n_items; i++) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          add_cmd(CmdPush, $urandom_range(2**KEY_W - 1, NUM_BUCKETS), $urandom);
        end else if (roll < 4 + push_pct * 96 / 100) begin
          add_cmd(CmdPush, base + $urandom_range(span - 1), $urandom);
        end else begin
          add_cmd(CmdPop, $urandom_range(2**KEY_W - 1), $urandom);
        end
        n++;
      end
    end
  endfunction

  // driver: hold a launched command until its transfer, then advance
  always @(posedge clk_i) begin
    queue_cmd_t head;
    bit         taken;
    bit         go;
    bit         settled;
    taken   = rst_ni && start && !busy;
    go      = 1'b0;
    settled = !taken && (n_issued == n_returned + int'(result_valid_o));
    if (taken) begin
      apply_command(cmd_q.pop_front());
      n_issued <= n_issued + 1;
    end
    if (rst_ni && cmd_q.size() > 0) begin
      head = cmd_q[0];
      if (start && !taken) begin
        go = 1'b1;
      end else if (head.drain_first && !settled) begin
        go = 1'b0;
      end else begin
        go = ($urandom_range(99) >= head.gap_pct);
      end
      if (go) begin
        command_i <= head.op;
        key_i     <= head.key;
        value_i   <= head.value;
      end
    end
    start <= go;
  end

  // monitor
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && result_valid_o) begin
      n_returned <= n_returned + 1;
      if (reply_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: value=%h key=%0d status=%0d occ=%0d",
                   pop_value_o, pop_key_o, status_o, occupancy_o);
      end else begin
        want = reply_q.pop_front();
        if (pop_value_o !== want.value || pop_key_o !== want.key ||
            status_o !== want.status || occupancy_o !== want.occ) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp value=%h key=%0d status=%0d occ=%0d",
                     want.value, want.key, want.status, want.occ,
                     ", got value=%h key=%0d status=%0d occ=%0d",
                     pop_value_o, pop_key_o, status_o, occupancy_o);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb_bucket_priority_queue: FAIL");
    $finish;
  end

  initial begin
    add_cmd(CmdPop, 0, 32'h0);
    add_cmd(CmdPush, 0, 32'h0000_0000);
    add_cmd(CmdPush, NUM_BUCKETS - 1, 32'hFFFF_FFFF);
    add_cmd(CmdPush, NUM_BUCKETS, 32'h1234_5678);
    add_cmd(CmdPush, 2**KEY_W - 1, 32'hFFFF_FFFF);
    add_cmd(CmdPop, 2**KEY_W - 1, 32'hFFFF_FFFF);
    add_cmd(CmdPop, 0, 32'h0);
    add_cmd(CmdPop, 0, 32'h0);
    for (int i = 0; i <= BUCKET_DEPTH; i++) add_cmd(CmdPush, 3, 32'hA5A5_0000 + i);

    build_phase(290, 0);
    build_phase(290, 62);
    build_phase(290, 20);
    build_phase(290, 62);
    build_phase(290, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (cmd_q.size() != 0 || start || n_issued != n_returned);
    repeat (10) @(posedge clk_i);

    if (n_bad == 0 && reply_q.size() == 0) begin
      $display("tb_bucket_priority_queue: PASS");
    end else begin
      $display("tb_bucket_priority_queue: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bpq_pkg.sv
rtl/core/bpq_ram.sv
rtl/core/bpq_lowest.sv
rtl/core/bucket_priority_queue.sv
tb/tb_bucket_priority_queue.sv
